>>> sv/sha384_byte_stream_hasher_macros.svh
// assertion macros for the sha-384 hasher
// no dependencies
`ifndef SHA384_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA384_BYTE_STREAM_HASHER_MACROS_SVH
// implication checked on every clock edge outside reset
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> sv/sha384_pkg.sv
// package for the sha-384 byte stream hasher: types, constants, round functions
// no dependencies
`timescale 1ns / 1ps
package sha384_pkg;
    localparam int BlockBytes = 128;
    localparam int DigestWords = 6;
    localparam int Rounds = 80;
    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [6:0] LenPos = 7'd120;
    localparam logic [6:0] SplitPos = 7'd112;

    typedef logic [63:0] word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_LOAD,
        ST_WAIT_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    // padding source of one byte position
    typedef enum logic [1:0] {
        FILL_ZERO,
        FILL_MARK,
        FILL_LEN
    } fill_t;

    typedef struct packed {
        logic       init;
        logic       buf_we;
        logic [6:0] buf_addr;
        logic [7:0] buf_data;
        logic       load_word;
        logic [3:0] load_idx;
        logic       round_start;
        logic       round_en;
        logic [6:0] round_idx;
        logic       fold;
        logic       len_add;
    } dp_cmd_t;

    typedef struct packed {
        logic [6:0] fill;
        logic [63:0] bit_len;
    } dp_status_t;

    function automatic word_t init_h(input logic [2:0] i);
        case (i)
            3'd0: init_h = 64'hcbbb9d5dc1059ed8;
            3'd1: init_h = 64'h629a292a367cd507;
            3'd2: init_h = 64'h9159015a3070dd17;
            3'd3: init_h = 64'h152fecd8f70e5939;
            3'd4: init_h = 64'h67332667ffc00b31;
            3'd5: init_h = 64'h8eb44a8768581511;
            3'd6: init_h = 64'hdb0c2e0d64f98fa7;
            default: init_h = 64'h47b5481dbefa4fa4;
        endcase
    endfunction

    localparam word_t RoundK [Rounds] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction
endpackage

>>> sv/sha384_if.sv
// valid/ready channel interfaces for the sha-384 hasher
// depends on nothing
`timescale 1ns / 1ps
interface sha384_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;
    modport source (output valid, action, data_byte, input ready);
    modport sink (input valid, action, data_byte, output ready);
endinterface

interface sha384_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> sv/sha384_ram.sv
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module sha384_ram #(
    parameter int Width = 8,
    parameter int Depth = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> sv/sha384_dp.sv
// sha-384 datapath: byte buffer ram, message schedule, round unit, chaining value
// depends on sha384_pkg and sha384_ram
`timescale 1ns / 1ps
module sha384_dp
    import sha384_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  fill_t      fill_sel,
    input  logic       use_ram,
    input  logic [2:0] byte_sel,
    output dp_status_t status,
    output word_t      h_word [DigestWords]
);
    logic [7:0]  ram_rdata;
    word_t       h_reg [8];
    word_t       w_reg [16];
    word_t       a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, hh_reg;
    word_t       asm_reg;
    logic [6:0]  fill_reg;
    logic [63:0] len_reg;
    logic [7:0]  byte_in;
    word_t       w_cur, w_new, t1, t2;

    sha384_ram #(.Width(8), .Depth(BlockBytes)) u_buf (
        .clk(clk), .we(cmd.buf_we), .addr(cmd.buf_addr), .wdata(cmd.buf_data),
        .rdata(ram_rdata)
    );

    // byte for the word being assembled
    always_comb
    begin
        byte_in = 8'h00;
        if (use_ram)
        begin
            byte_in = ram_rdata;
        end
        else
        begin
            case (fill_sel)
                FILL_MARK: byte_in = PadByte;
                FILL_LEN:  byte_in = len_reg[8*(7-byte_sel) +: 8];
                default:   byte_in = 8'h00;
            endcase
        end
    end

    assign w_cur = w_reg[0];
    assign w_new = w_reg[0] + (rotr(w_reg[1], 1) ^ rotr(w_reg[1], 8) ^ (w_reg[1] >> 7))
                 + w_reg[9] + (rotr(w_reg[14], 19) ^ rotr(w_reg[14], 61) ^ (w_reg[14] >> 6));
    assign t1 = hh_reg + (rotr(e_reg, 14) ^ rotr(e_reg, 18) ^ rotr(e_reg, 41))
              + ((e_reg & f_reg) ^ (~e_reg & g_reg)) + RoundK[cmd.round_idx] + w_cur;
    assign t2 = (rotr(a_reg, 28) ^ rotr(a_reg, 34) ^ rotr(a_reg, 39))
              + ((a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            len_reg  <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_h(3'(i));
            end
        end
        else
        begin
            if (cmd.init)
            begin
                fill_reg <= '0;
                len_reg  <= '0;
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= init_h(3'(i));
                end
            end
            else
            begin
                if (cmd.buf_we)
                begin
                    fill_reg <= fill_reg + 7'd1;
                end
                if (cmd.len_add)
                begin
                    len_reg <= len_reg + 64'd8;
                end
                if (cmd.fold)
                begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    h_reg[5] <= h_reg[5] + f_reg;
                    h_reg[6] <= h_reg[6] + g_reg;
                    h_reg[7] <= h_reg[7] + hh_reg;
                end
            end
        end
    end

    // word assembly, schedule window and working variables
    always_ff @(posedge clk)
    begin
        if (cmd.load_word)
        begin
            asm_reg <= {asm_reg[55:0], byte_in};
            if (byte_sel == 3'd7)
            begin
                w_reg[cmd.load_idx] <= {asm_reg[55:0], byte_in};
            end
        end
        if (cmd.round_start)
        begin
            a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2]; d_reg <= h_reg[3];
            e_reg <= h_reg[4]; f_reg <= h_reg[5]; g_reg <= h_reg[6]; hh_reg <= h_reg[7];
        end
        else if (cmd.round_en)
        begin
            hh_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg; e_reg <= d_reg + t1;
            d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg; a_reg <= t1 + t2;
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
    end

    assign status.fill    = fill_reg;
    assign status.bit_len = len_reg;
    always_comb
    begin
        for (int i = 0; i < DigestWords; i++)
        begin
            h_word[i] = h_reg[i];
        end
    end
endmodule

>>> sv/sha384_ctrl.sv
// sha-384 controller: absorb, padding sequence, round count and digest emission
// depends on sha384_pkg and the macros header
`timescale 1ns / 1ps
`include "sha384_byte_stream_hasher_macros.svh"
module sha384_ctrl
    import sha384_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       in_action,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] out_index,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output fill_t      fill_sel,
    output logic       use_ram,
    output logic [2:0] byte_sel
);
    state_t     state_reg, state_next;
    logic [6:0] pos_reg, pos_next;     // byte position in the block being padded or loaded
    logic       second_reg, second_next; // a length-only block still follows
    logic       tail_reg, tail_next;     // length-only block in progress, mark already placed
    logic       final_reg, final_next;   // compressing for a finish
    logic [6:0] n_reg, n_next;         // bytes buffered at finish
    logic [6:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;
    logic       in_tx;

    assign in_tx = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            second_reg <= 1'b0;
            tail_reg   <= 1'b0;
            final_reg  <= 1'b0;
            n_reg      <= '0;
            rnd_reg    <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            second_reg <= second_next;
            tail_reg   <= tail_next;
            final_reg  <= final_next;
            n_reg      <= n_next;
            rnd_reg    <= rnd_next;
            idx_reg    <= idx_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        second_next = second_reg;
        tail_next   = tail_reg;
        final_next  = final_reg;
        n_next      = n_reg;
        rnd_next    = rnd_reg;
        idx_next    = idx_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        fill_sel    = FILL_ZERO;
        use_ram     = 1'b0;
        byte_sel    = pos_reg[2:0];
        cmd.buf_addr  = pos_reg;
        cmd.load_idx  = pos_reg[6:3];
        cmd.round_idx = rnd_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.buf_addr = status.fill;
                cmd.buf_data = in_byte;
                if (in_tx)
                begin
                    if (!in_action)
                    begin
                        cmd.buf_we  = 1'b1;
                        cmd.len_add = 1'b1;
                        if (status.fill == 7'd127)
                        begin
                            final_next = 1'b0;
                            pos_next   = '0;
                            cmd.buf_addr = status.fill;
                            state_next = ST_WAIT_LOAD;
                        end
                    end
                    else
                    begin
                        final_next  = 1'b1;
                        n_next      = status.fill;
                        second_next = (status.fill >= SplitPos);
                        tail_next   = 1'b0;
                        pos_next    = '0;
                        state_next  = ST_PAD;
                    end
                end
            end
            // wait state for the registered ram read of byte 0 before streaming bytes
            ST_WAIT_LOAD:
            begin
                cmd.buf_addr = '0;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // ram read of pos issued last cycle; issue pos + 1 now
                cmd.buf_addr  = pos_reg + 7'd1;
                use_ram       = 1'b1;
                cmd.load_word = 1'b1;
                pos_next      = pos_reg + 7'd1;
                if (pos_reg == 7'd127)
                begin
                    rnd_next = '0;
                    cmd.round_start = 1'b1;
                    state_next = ST_ROUND;
                end
            end
            ST_PAD:
            begin
                cmd.buf_addr  = pos_reg;
                cmd.load_word = 1'b0;
                // padded block: buffered bytes, then mark, zeros and, in the last block, the length
                if (pos_reg < n_reg)
                begin
                    // fetch through the ram: the read is issued here and the byte is taken in ST_LEN
                    state_next = ST_LEN;
                end
                else
                begin
                    cmd.load_word = 1'b1;
                    if (pos_reg == n_reg && !tail_reg)
                    begin
                        fill_sel = FILL_MARK;
                    end
                    else if (pos_reg >= LenPos && !second_reg)
                    begin
                        fill_sel = FILL_LEN;
                    end
                    pos_next = pos_reg + 7'd1;
                    if (pos_reg == 7'd127)
                    begin
                        rnd_next = '0;
                        cmd.round_start = 1'b1;
                        state_next = ST_ROUND;
                    end
                end
            end
            // ram data for a buffered byte is now valid
            ST_LEN:
            begin
                cmd.buf_addr  = pos_reg;
                use_ram       = 1'b1;
                cmd.load_word = 1'b1;
                pos_next      = pos_reg + 7'd1;
                state_next    = ST_PAD;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'(Rounds - 1))
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
                pos_next = '0;
                if (!final_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (second_reg)
                begin
                    // length-only block: nothing buffered, mark already placed
                    second_next = 1'b0;
                    tail_next   = 1'b1;
                    n_next      = 7'd0;
                    state_next  = ST_PAD;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'(DigestWords - 1))
                    begin
                        cmd.init   = 1'b1;
                        final_next = 1'b0;
                        tail_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_index = idx_reg;

    `SHA_ASSERT_IMP(a_no_accept_busy, state_reg != ST_IDLE, !in_ready, "input taken while busy")
    `SHA_ASSERT_IMP(a_emit_only, out_valid, state_reg == ST_EMIT && idx_reg < 3'd6, "bad output")
    `SHA_ASSERT_NEXT(a_round_len, state_reg == ST_ROUND && rnd_reg != 7'd79, state_reg == ST_ROUND, "round sequence broken")
    `SHA_ASSERT_NEXT(a_finish_back, state_reg == ST_EMIT && out_ready && idx_reg == 3'd5, state_reg == ST_IDLE && status.fill == 7'd0, "no return to idle")
endmodule

>>> sv/sha384_byte_stream_hasher.sv
// sha-384 byte stream hasher top level: one byte per transaction in, six digest words out
// a byte is absorbed in ST_IDLE; a full block adds a ram wait, the load, 80 rounds and a fold
// finish: padding load with a ram wait per buffered byte, 80 rounds, fold, repeated for a
// second block when 112 or more bytes are buffered, then six output transactions
// throughput is set by the single shared round unit and the one-port byte buffer
// reset (rst_n, asynchronous, active low) restores the initial chaining value, length and fill
`timescale 1ns / 1ps
module sha384_byte_stream_hasher
    import sha384_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sha384_in_if.sink    in_ch,
    sha384_out_if.source out_ch
);
    dp_cmd_t    cmd;
    dp_status_t status;
    fill_t      fill_sel;
    logic       use_ram;
    logic [2:0] byte_sel;
    logic [2:0] idx;
    word_t      h_word [DigestWords];

    // controller sequences absorb, padding, rounds and output transactions
    sha384_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .in_action(in_ch.action), .in_byte(in_ch.data_byte),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_index(idx),
        .status(status), .cmd(cmd), .fill_sel(fill_sel), .use_ram(use_ram),
        .byte_sel(byte_sel)
    );

    // datapath holds the buffer, schedule, working variables and chaining value
    sha384_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .fill_sel(fill_sel), .use_ram(use_ram),
        .byte_sel(byte_sel), .status(status), .h_word(h_word)
    );

    // digest word picked straight from the chaining value, held while emitting
    assign out_ch.digest_word = (idx < 3'(DigestWords)) ? h_word[idx] : '0;
    assign out_ch.word_index  = idx;
    assign out_ch.last_word   = (idx == 3'(DigestWords - 1));
endmodule

>>> tb/sha384_hasher_scoreboard.sv
// digest predictor and checker for the sha-384 byte stream hasher testbench
// depends on sha384_pkg for the word type
`timescale 1ns / 1ps
package sha384_hasher_scoreboard_pkg;
    import sha384_pkg::*;

    typedef struct {
        word_t      digest_word;
        logic [2:0] word_index;
        logic       last_word;
    } digest_item_t;

    localparam word_t K512 [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam word_t IV384 [8] = '{
        64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
        64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
    };

    class digest_scoreboard;
        word_t          hash_state [8];
        logic [7:0]     msg_block [128];
        int unsigned    bytes_held;
        logic [63:0]    msg_bits;
        digest_item_t   pending_words [$];
        int unsigned    error_count;

        function new();
            error_count = 0;
            restart();
        endfunction

        function void restart();
            hash_state = IV384;
            foreach (msg_block[i]) msg_block[i] = 8'h00;
            bytes_held = 0;
            msg_bits = '0;
        endfunction

        static function word_t ror(word_t x, int n);
            return (x >> n) | (x << (64 - n));
        endfunction

        function void compress_block(logic [7:0] blk [128]);
            word_t sched [80];
            word_t a, b, c, d, e, f, g, h, t1, t2, s0, s1;
            for (int i = 0; i < 16; i++)
                for (int j = 0; j < 8; j++)
                    sched[i] = {sched[i][55:0], blk[i*8+j]};
            for (int i = 16; i < 80; i++)
            begin
                s0 = ror(sched[i-15], 1) ^ ror(sched[i-15], 8) ^ (sched[i-15] >> 7);
                s1 = ror(sched[i-2], 19) ^ ror(sched[i-2], 61) ^ (sched[i-2] >> 6);
                sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
            end
            {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2],
                hash_state[3], hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
            for (int i = 0; i < 80; i++)
            begin
                t1 = h + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41)) + ((e & f) ^ (~e & g))
                    + K512[i] + sched[i];
                t2 = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
            hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
        endfunction

        // one accepted input transaction
        function void note_input(logic finish, logic [7:0] data_byte);
            logic [7:0] tail [128];
            digest_item_t w;
            if (!finish)
            begin
                msg_block[bytes_held] = data_byte;
                bytes_held++;
                msg_bits += 64'd8;
                if (bytes_held == 128)
                begin
                    compress_block(msg_block);
                    bytes_held = 0;
                end
                return;
            end
            foreach (tail[i]) tail[i] = (i < bytes_held) ? msg_block[i] : 8'h00;
            tail[bytes_held] = 8'h80;
            if (bytes_held >= 112)
            begin
                compress_block(tail);
                foreach (tail[i]) tail[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++) tail[120+i] = msg_bits[63-8*i -: 8];
            compress_block(tail);
            for (int i = 0; i < 6; i++)
            begin
                w.digest_word = hash_state[i];
                w.word_index = 3'(i);
                w.last_word = (i == 5);
                pending_words.push_back(w);
            end
            restart();
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $time, what);
            error_count++;
        endtask

        // one accepted output transaction
        task check_word(word_t dw, logic [2:0] idx, logic lw);
            digest_item_t w;
            if (pending_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word %h idx %0d", dw, idx));
                return;
            end
            w = pending_words.pop_front();
            if (dw !== w.digest_word)
                report_mismatch($sformatf("word %0d: got %h want %h", w.word_index, dw,
                    w.digest_word));
            if (idx !== w.word_index)
                report_mismatch($sformatf("index: got %0d want %0d", idx, w.word_index));
            if (lw !== w.last_word)
                report_mismatch($sformatf("last flag: got %b want %b", lw, w.last_word));
        endtask
    endclass
endpackage

>>> tb/sha384_byte_stream_hasher_tb.sv
// self-checking testbench for the sha-384 byte stream hasher
// depends on sha384_pkg, sha384_if and the scoreboard package
`timescale 1ns / 1ps
module sha384_byte_stream_hasher_tb;
    import sha384_pkg::*;
    import sha384_hasher_scoreboard_pkg::*;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   sink_stall_pct;

    sha384_in_if  in_ch ();
    sha384_out_if out_ch ();

    digest_scoreboard digests;

    sha384_byte_stream_hasher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: the worst case per block plus stalls stays far below this
    initial
    begin
        #20ms;
        $display("FAIL sha384_byte_stream_hasher");
        $finish;
    end

    // receiver side: random back-pressure, check every accepted transaction
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                digests.check_word(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // send one transaction, with random idle cycles in front of it
    task automatic send_item(logic act, logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.data_byte <= b;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        digests.note_input(act, b);
    endtask

    // a whole message of random bytes closed by a finish
    task automatic send_message(int len);
        for (int i = 0; i < len; i++)
            send_item(ACT_ABSORB, 8'($urandom_range(255)));
        send_item(ACT_FINISH, 8'($urandom_range(255)));
    endtask

    initial
    begin
        int phase_idle [4];
        int phase_stall [4];
        int guard;
        phase_idle  = '{0, 58, 0, 38};
        phase_stall = '{0, 0, 58, 38};
        digests = new();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_ABSORB;
        in_ch.data_byte = 8'h00;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, "abc", extreme bytes, finish byte ignored
        send_item(ACT_FINISH, 8'hff);
        send_item(ACT_ABSORB, 8'h61);
        send_item(ACT_ABSORB, 8'h62);
        send_item(ACT_ABSORB, 8'h63);
        send_item(ACT_FINISH, 8'h00);
        send_item(ACT_ABSORB, 8'h00);
        send_item(ACT_ABSORB, 8'hff);
        send_item(ACT_ABSORB, 8'haa);
        send_item(ACT_ABSORB, 8'h55);
        send_item(ACT_FINISH, 8'h80);
        send_item(ACT_FINISH, 8'h7f);

        // short random messages over four idle and stall phases; one message
        // at the padding split needs a second, length-only block
        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct = phase_idle[p];
            sink_stall_pct = phase_stall[p];
            if (p == 1)
                send_message(112);
            for (int m = 0; m < 2; m++) send_message($urandom_range(0, 12));
        end
        in_ch.valid <= 1'b0;

        // drain
        guard = 0;
        while (digests.pending_words.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (50) @(posedge clk);
        if (digests.pending_words.size() == 0 && digests.error_count == 0)
            $display("PASS sha384_byte_stream_hasher");
        else
            $display("FAIL sha384_byte_stream_hasher");
        $finish;
    end
endmodule

>>> sim.f
+incdir+sv
sv/sha384_pkg.sv
sv/sha384_if.sv
sv/sha384_ram.sv
sv/sha384_dp.sv
sv/sha384_ctrl.sv
sv/sha384_byte_stream_hasher.sv
tb/sha384_hasher_scoreboard.sv
tb/sha384_byte_stream_hasher_tb.sv
